FILE: hdl/cctl_pkg.sv
// ----------------------------------------------------------------------------
// cctl_pkg
// Shared types, constants and helper functions for the cube cover to LUT
// truth table block.
// ----------------------------------------------------------------------------
package cctl_pkg;

  localparam int MAX_INPUTS     = 6;
  localparam int TABLE_W        = 1 << MAX_INPUTS;
  localparam int K_W            = 3;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 3;

  typedef logic [TABLE_W-1:0]        table_t;
  typedef logic [MAX_INPUTS-1:0]     lits_t;
  typedef logic [K_W-1:0]            k_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]     cfg_data_t;

  // Input commands.
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_INPUT_COUNT = 1'b0;
  localparam cfg_idx_t CFG_DEFAULT_BIT = 1'b1;

  typedef struct packed {
    logic  command;
    lits_t care_mask;
    lits_t literal_values;
    logic  output_bit;
  } item_t;

  // Out-of-range input counts are pulled into 1..MAX_INPUTS.
  function automatic k_t clamp_inputs(input k_t raw);
    k_t k;
    k = raw;
    if (raw == k_t'(0)) begin
      k = k_t'(1);
    end else if (raw > k_t'(MAX_INPUTS)) begin
      k = k_t'(MAX_INPUTS);
    end
    return k;
  endfunction

  // One bit per table entry that exists for k inputs.
  function automatic table_t entries_mask(input k_t k);
    table_t m;
    for (int n = 0; n < TABLE_W; n++) begin
      m[n] = (n < (32'd1 << k));
    end
    return m;
  endfunction

endpackage

FILE: hdl/cctl_cube_match.sv
// ----------------------------------------------------------------------------
// cctl_cube_match
// Per-entry match logic: flags every table entry whose index agrees with
// the cared literals of one cube.
// ----------------------------------------------------------------------------
module cctl_cube_match (
  input  cctl_pkg::lits_t  care_mask,
  input  cctl_pkg::lits_t  literal_values,
  input  cctl_pkg::k_t     k,
  output cctl_pkg::table_t hit
);
  import cctl_pkg::*;

  lits_t  in_mask;
  lits_t  care_eff;
  lits_t  want;
  table_t raw_hit;

  always_comb begin
    for (int i = 0; i < MAX_INPUTS; i++) begin
      in_mask[i] = (i < int'(k));
    end
    care_eff = care_mask & in_mask;
    // An index bit is 1 where the literal is 0.
    want     = ~literal_values & care_eff;
    for (int n = 0; n < TABLE_W; n++) begin
      raw_hit[n] = ((lits_t'(n) & care_eff) == want);
    end
  end

  assign hit = raw_hit & entries_mask(k);

endmodule

FILE: hdl/cctl_cover_core.sv
// ----------------------------------------------------------------------------
// cctl_cover_core
// Cover state (table, touched entries, seen flags) and the result register.
// An added cube updates the state; an emit builds the table and clears it.
// ----------------------------------------------------------------------------
module cctl_cover_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             proc,
  input  cctl_pkg::item_t  item,
  input  cctl_pkg::k_t     k,
  input  logic             default_bit,
  input  logic             out_ready,
  output logic             out_valid,
  output cctl_pkg::table_t out_lut_table
);
  import cctl_pkg::*;

  table_t table_r, table_nxt;
  table_t touched_r, touched_nxt;
  logic   seen_on_r, seen_on_nxt;
  logic   seen_any_r, seen_any_nxt;
  logic   out_valid_r, out_valid_nxt;
  table_t out_lut_r, out_lut_nxt;
  table_t hit;
  table_t fill;
  logic   is_emit;

  cctl_cube_match u_match (
    .care_mask      (item.care_mask),
    .literal_values (item.literal_values),
    .k              (k),
    .hit            (hit)
  );

  assign is_emit = (item.command == CMD_EMIT);

  always_comb begin
    table_nxt     = table_r;
    touched_nxt   = touched_r;
    seen_on_nxt   = seen_on_r;
    seen_any_nxt  = seen_any_r;
    out_lut_nxt   = out_lut_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (!seen_any_r) begin
      fill = {TABLE_W{default_bit}};
    end else begin
      fill = {TABLE_W{!seen_on_r}};
    end
    if (proc) begin
      if (is_emit) begin
        out_lut_nxt   = ((table_r & touched_r) | (fill & ~touched_r)) & entries_mask(k);
        out_valid_nxt = 1'b1;
        table_nxt     = '0;
        touched_nxt   = '0;
        seen_on_nxt   = 1'b0;
        seen_any_nxt  = 1'b0;
      end else begin
        table_nxt    = (table_r & ~hit) | (item.output_bit ? hit : '0);
        touched_nxt  = touched_r | hit;
        seen_any_nxt = 1'b1;
        seen_on_nxt  = seen_on_r | item.output_bit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_r     <= '0;
      touched_r   <= '0;
      seen_on_r   <= 1'b0;
      seen_any_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      table_r     <= table_nxt;
      touched_r   <= touched_nxt;
      seen_on_r   <= seen_on_nxt;
      seen_any_r  <= seen_any_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_lut_r <= out_lut_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_lut_table = out_lut_r;

`ifndef ASSERT_OFF
  a_on_implies_any: assert property (@(posedge clk) disable iff (!rst_n)
    seen_on_r |-> seen_any_r) else $error("on-set flag without any line");

  a_table_within_touched: assert property (@(posedge clk) disable iff (!rst_n)
    (table_r & ~touched_r) == '0) else $error("table bit set on untouched entry");

  a_touched_implies_any: assert property (@(posedge clk) disable iff (!rst_n)
    (touched_r != '0) |-> seen_any_r) else $error("touched entries without any line");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && is_emit) |=> (touched_r == '0) && !seen_any_r && out_valid_r)
    else $error("emit did not clear the cover");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && is_emit) |-> (!out_valid_r || out_ready))
    else $error("emit would overwrite a pending result");
`endif

endmodule

FILE: hdl/cube_cover_to_lut_table.sv
// ----------------------------------------------------------------------------
// cube_cover_to_lut_table
// Builds the configuration bits of a LUT of up to six inputs from a cover
// of product cubes presented one cube per item.
// ----------------------------------------------------------------------------
// Usage:
// Each input item is either an add, which folds one cube (care mask,
// literal values and output bit) into the cover, or an emit, which returns
// the finished 64-bit table on the result channel and clears the cover.
// Adds produce no result item; every emit produces exactly one.
// Items pass through an input register and then a single stage of match
// and update logic into the result register, from which an emit's table
// is presented with out_valid. One item can be accepted in every cycle while
// no emit is held waiting; the per-entry match logic across all 64 entries
// sets the cycle time. When the receiver stalls, the pending result is held
// and further adds are still absorbed; an emit waits in the input register
// until the result register is free, and in_ready stays low while it waits.
// A synchronous reset (rst_n low) empties both registers, clears the cover
// and sets the input count to 6 and default_bit to 0. The configuration
// port is to be written only while the block is idle.
// ----------------------------------------------------------------------------
module cube_cover_to_lut_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_command,
  input  cctl_pkg::lits_t     in_care_mask,
  input  cctl_pkg::lits_t     in_literal_values,
  input  logic                in_output_bit,
  output logic                out_valid,
  input  logic                out_ready,
  output cctl_pkg::table_t    out_lut_table,
  input  logic                cfg_we,
  input  cctl_pkg::cfg_idx_t  cfg_index,
  input  cctl_pkg::cfg_data_t cfg_data
);
  import cctl_pkg::*;

  // Configuration registers.
  k_t    input_count_r;
  logic  default_bit_r;

  // Input register.
  logic  s1_valid_r, s1_valid_nxt;
  item_t s1_item_r, s1_item_nxt;

  logic  advance;
  logic  in_fire;
  logic  core_out_valid;

  // An add never needs the result register, so it always moves on; an emit
  // moves on only when the result register is empty or being emptied.
  assign advance  = s1_valid_r &&
                    ((s1_item_r.command == CMD_ADD) || !core_out_valid || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_item_nxt  = s1_item_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
      s1_item_nxt  = '{command:        in_command,
                       care_mask:      in_care_mask,
                       literal_values: in_literal_values,
                       output_bit:     in_output_bit};
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      input_count_r <= k_t'(MAX_INPUTS);
      default_bit_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_INPUT_COUNT: input_count_r <= cfg_data[K_W-1:0];
          CFG_DEFAULT_BIT: default_bit_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
    s1_item_r <= s1_item_nxt;
  end

  cctl_cover_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .proc          (advance),
    .item          (s1_item_r),
    .k             (clamp_inputs(input_count_r)),
    .default_bit   (default_bit_r),
    .out_ready     (out_ready),
    .out_valid     (core_out_valid),
    .out_lut_table (out_lut_table)
  );

  assign out_valid = core_out_valid;

endmodule
